FILE: hw/rtl/purl_pkg.sv
// shared types and constants of the per-user request rate limiter
package purl_pkg;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MINUTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HOUR = 2'd2;

  localparam logic [15:0] LIMIT_MINUTE_RESET = 16'd60;
  localparam logic [15:0] LIMIT_HOUR_RESET = 16'd1000;

  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam logic [15:0] COUNT_ONE = 16'd1;
  localparam logic [32:0] MINUTE_SECS = 33'd60;
  localparam logic [32:0] HOUR_SECS = 33'd3600;

  typedef struct packed {
    logic [31:0] user_id;
    logic [31:0] now;
  } req_word_t;

  typedef struct packed {
    logic [32:0] retry_at;
    logic        table_full;
  } rsp_word_t;

  // one table entry as held in the stats ram
  typedef struct packed {
    logic [31:0] user_id;
    logic [31:0] last_seen;
    logic [15:0] minute_count;
    logic [15:0] hour_count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/purl_ram.sv
// generic single-write, single-read ram with registered read data
module purl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/per_user_request_rate_limiter.sv
// per-user request rate limiter: table scan, count update and result register
// path: a disabled request goes straight to the result; a known user ends the scan at
//   its entry, a new or untracked user scans all fill entries (fill = users stored)
// throughput: one request at a time, set by the one-entry-per-cycle scan of the
//   stats ram; the next request is taken while the last result waits
// reset: control registers clear, config registers take their reset values,
//   fill count goes to zero so the table reads as empty; ram contents are not cleared
module per_user_request_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  purl_pkg::req_word_t                 req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output purl_pkg::rsp_word_t                 rsp,
  input  logic                                cfg_we,
  input  logic [purl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [purl_pkg::CFG_W-1:0]          cfg_data
);
  import purl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_MISS   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // config registers
  logic        enable;
  logic [15:0] limit_per_minute;
  logic [15:0] limit_per_hour;

  // control
  logic [2:0]        state;
  logic [FILL_W-1:0] fill;
  logic [AW-1:0]     scan_addr;

  // payload holding registers
  req_word_t req_q;
  entry_t    hold;
  logic [AW-1:0] hit_addr;
  rsp_word_t res;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t        rd_entry;

  // update arithmetic
  logic signed [32:0] gap;
  logic [15:0] minute_base;
  logic [15:0] hour_base;
  logic [15:0] minute_new;
  logic [15:0] hour_new;
  logic [32:0] retry_new;
  logic        scan_hit;
  logic        scan_last;
  logic        rsp_free;

  assign rd_entry  = entry_t'(ram_rdata);
  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // a valid entry is one below the fill count, so the scan stops at fill-1
  assign scan_hit  = (rd_entry.user_id == req_q.user_id);
  assign scan_last = (FILL_W'(scan_addr) == FILL_W'(fill - FILL_ONE));

  // read address: entry 0 when a request is taken, next entry while scanning
  always_comb begin
    if (state == S_SCAN) begin
      ram_raddr = AW'(scan_addr + AW'(1));
    end else begin
      ram_raddr = '0;
    end
  end

  // window logic on the entry that matched
  always_comb begin
    gap = signed'({1'b0, req_q.now}) - signed'({1'b0, hold.last_seen});
    minute_base = (gap >= signed'(MINUTE_SECS)) ? 16'd0 : hold.minute_count;
    hour_base   = (gap >= signed'(HOUR_SECS)) ? 16'd0 : hold.hour_count;
    // saturating increment
    minute_new = (minute_base == COUNT_MAX) ? COUNT_MAX : minute_base + COUNT_ONE;
    hour_new   = (hour_base == COUNT_MAX) ? COUNT_MAX : hour_base + COUNT_ONE;
    if (minute_new >= limit_per_minute) begin
      retry_new = {1'b0, hold.last_seen} + MINUTE_SECS;
    end else if (hour_new >= limit_per_hour) begin
      retry_new = {1'b0, hold.last_seen} + HOUR_SECS;
    end else begin
      retry_new = '0;
    end
  end

  // write-back: updated entry on a hit, fresh entry at the fill point on a miss if not full
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_addr;
    ram_wdata = '{user_id: req_q.user_id, last_seen: req_q.now,
                  minute_count: minute_new, hour_count: hour_new};
    case (state)
      S_UPDATE: begin
        ram_we = 1'b1;
      end
      S_MISS: begin
        ram_we    = (fill != FILL_MAX);
        ram_waddr = fill[AW-1:0];
        ram_wdata = '{user_id: req_q.user_id, last_seen: req_q.now,
                      minute_count: COUNT_ONE, hour_count: COUNT_ONE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  purl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_stats_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      fill             <= '0;
      scan_addr        <= '0;
      rsp_valid        <= 1'b0;
      enable           <= 1'b0;
      limit_per_minute <= LIMIT_MINUTE_RESET;
      limit_per_hour   <= LIMIT_HOUR_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:       enable <= cfg_data[0];
          REG_LIMIT_MINUTE: limit_per_minute <= cfg_data;
          REG_LIMIT_HOUR:   limit_per_hour <= cfg_data;
          default:          ;
        endcase
      end

      // output register: load from the result holder, drop when taken
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            scan_addr <= '0;
            if (!enable) begin
              state <= S_DONE;
            end else if (fill == '0) begin
              state <= S_MISS;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            state <= S_UPDATE;
          end else if (scan_last) begin
            state <= S_MISS;
          end else begin
            scan_addr <= AW'(scan_addr + AW'(1));
          end
        end
        S_UPDATE: begin
          state <= S_DONE;
        end
        S_MISS: begin
          if (fill != FILL_MAX) begin
            fill <= FILL_W'(fill + FILL_ONE);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
      res   <= '0;
    end
    if (state == S_SCAN && scan_hit) begin
      hold     <= rd_entry;
      hit_addr <= scan_addr;
    end
    if (state == S_UPDATE) begin
      res.retry_at   <= retry_new;
      res.table_full <= 1'b0;
    end
    if (state == S_MISS) begin
      res.retry_at   <= '0;
      res.table_full <= (fill == FILL_MAX);
    end
    if (state == S_DONE && rsp_free) begin
      rsp <= res;
    end
  end

endmodule

FILE: test/tb_per_user_request_rate_limiter.sv
// self-checking testbench for the per-user request rate limiter
module tb_per_user_request_rate_limiter;
  timeunit 1ns;
  timeprecision 1ps;
  import purl_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned RESET_CYCLES = 11;
  // room for about 600 words even with full scans and stalls
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES + 16;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [15:0] BUSY_WORDS = 16'd100;
  localparam int unsigned PHASE_WORDS = 70;
  localparam int unsigned RANDOM_PHASES = 6;

  // users of the directed tests
  localparam logic [31:0] USER_DEFAULTS = 32'h1234_5678;
  localparam logic [31:0] USER_BUSY = 32'h5a5a_0001;
  localparam logic [31:0] USER_LOW = 32'h0000_0000;
  localparam logic [31:0] USER_HIGH = 32'hffff_ffff;
  localparam logic [31:0] USER_MID = 32'h8000_0001;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ENABLE;
  logic [CFG_W-1:0]     cfg_data = '0;

  per_user_request_rate_limiter #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the user table and of the limit registers
  // ---------------------------------------------------------------------------
  bit          shadow_valid [TABLE_ENTRIES];
  logic [31:0] shadow_user [TABLE_ENTRIES];
  logic [31:0] shadow_last [TABLE_ENTRIES];
  logic [15:0] shadow_minute [TABLE_ENTRIES];
  logic [15:0] shadow_hour [TABLE_ENTRIES];
  bit          limiter_on = 1'b0;
  logic [15:0] minute_limit = LIMIT_MINUTE_RESET;
  logic [15:0] hour_limit = LIMIT_HOUR_RESET;

  // verdicts still owed by the block, oldest first
  rsp_word_t pending_verdicts [$];

  // run statistics
  int unsigned words_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned limited_seen = 0;
  int unsigned full_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned backpressure_cycles = 0;

  // sender pacing
  int unsigned burst_left = 0;
  bit          send_gaps = 1'b1;

  // receiver pacing; mode flags are set from the test tasks with nonblocking writes
  bit          rsp_idling = 1'b1;
  bit          hold_go = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_run = 0;
  bit          stall_phase = 1'b0;

  // users offered so far by the random traffic
  logic [31:0] user_pool [$];
  logic [31:0] wall_clock;

  // verdict for one request, updating the shadow table as the block would
  function automatic rsp_word_t rate_decision(logic [31:0] user, logic [31:0] now);
    rsp_word_t   verdict;
    int          hit;
    int          free_slot;
    longint      gap;
    logic [31:0] prev;
    logic [15:0] m;
    logic [15:0] h;
    verdict = '0;
    hit = -1;
    free_slot = -1;
    // disabled: allow and leave the table alone
    if (!limiter_on) return verdict;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        if (hit < 0 && shadow_user[i] == user) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        // no room: user goes untracked
        verdict.table_full = 1'b1;
      end else begin
        shadow_valid[free_slot] = 1'b1;
        shadow_user[free_slot] = user;
        shadow_last[free_slot] = now;
        shadow_minute[free_slot] = COUNT_ONE;
        shadow_hour[free_slot] = COUNT_ONE;
      end
    end else begin
      prev = shadow_last[hit];
      // signed gap, so time going backwards clears nothing
      gap = longint'({32'd0, now}) - longint'({32'd0, prev});
      m = shadow_minute[hit];
      h = shadow_hour[hit];
      if (gap >= longint'(MINUTE_SECS)) m = '0;
      if (gap >= longint'(HOUR_SECS)) h = '0;
      m = (m == COUNT_MAX) ? COUNT_MAX : m + COUNT_ONE;
      h = (h == COUNT_MAX) ? COUNT_MAX : h + COUNT_ONE;
      shadow_minute[hit] = m;
      shadow_hour[hit] = h;
      shadow_last[hit] = now;
      if (m >= minute_limit) verdict.retry_at = {1'b0, prev} + MINUTE_SECS;
      else if (h >= hour_limit) verdict.retry_at = {1'b0, prev} + HOUR_SECS;
    end
    return verdict;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one word and wait for the block to take it; valid stays high on return
  // so back-to-back words need no drop in between
  task automatic send_request(input logic [31:0] user, input logic [31:0] now);
    req_word_t   w;
    int unsigned gap_len;
    w.user_id = user;
    w.now = now;
    if (send_gaps && burst_left == 0) begin
      gap_len = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    pending_verdicts.push_back(rate_decision(user, now));
    words_sent++;
  endtask

  // register write only once the block has nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    req_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_ENABLE: limiter_on = val[0];
      REG_LIMIT_MINUTE: minute_limit = val;
      REG_LIMIT_HOUR: hour_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] per_minute, input logic [15:0] per_hour);
    write_reg(REG_LIMIT_MINUTE, per_minute);
    write_reg(REG_LIMIT_HOUR, per_hour);
  endtask

  // ---------------------------------------------------------------------------
  // response side: stall pattern, long hold-off, checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      // long hold-off so the block fills and pushes back on the request side
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!rsp_idling) begin
      rsp_stall <= 1'b0;
    end else begin
      // alternating runs of stall and accept with random lengths
      if (stall_run == 0) begin
        stall_phase = !stall_phase;
        stall_run = stall_phase ? $urandom_range(1, 5) : $urandom_range(1, 7);
      end
      stall_run--;
      rsp_stall <= stall_phase;
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_word_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("unexpected word retry_at=%0d table_full=%0b",
                             rsp.retry_at, rsp.table_full));
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp.retry_at !== want.retry_at)
          flag_error($sformatf("word %0d retry_at expected %0d got %0d",
                               verdicts_seen, want.retry_at, rsp.retry_at));
        if (rsp.table_full !== want.table_full)
          flag_error($sformatf("word %0d table_full expected %0b got %0b",
                               verdicts_seen, want.table_full, rsp.table_full));
        if (want.retry_at != '0) limited_seen++;
        if (want.table_full) full_seen++;
      end
    end
  end

  // cycle budget and back-pressure bookkeeping
  always @(posedge clk) begin
    cycle_count++;
    if (req_valid && req_stall === 1'b1) backpressure_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_count, pending_verdicts.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // limiter off after reset: everything allowed, table untouched
  task automatic test_disabled();
    send_request(USER_LOW, 32'd0);
    send_request(USER_HIGH, 32'hffff_ffff);
    send_request(USER_LOW, 32'd0);
    repeat (3) send_request($urandom, $urandom);
  endtask

  // only enable is written, so the reset limits of 60 and 1000 apply
  task automatic test_reset_limits();
    write_reg(REG_ENABLE, 16'd1);
    repeat (61) send_request(USER_DEFAULTS, 32'd50);
  endtask

  // one user hammered back to back at a fixed time until the hour count hits its limit
  task automatic test_busy_user();
    set_limits(COUNT_MAX, BUSY_WORDS);
    send_gaps = 1'b0;
    rsp_idling <= 1'b0;
    repeat (BUSY_WORDS) send_request(USER_BUSY, 32'd1000);
    // minute window rolls over, the hour count still limits
    send_request(USER_BUSY, 32'd1060);
    // hour window rolls over too
    send_request(USER_BUSY, 32'd4660);
    send_gaps = 1'b1;
    rsp_idling <= 1'b1;
  endtask

  task automatic test_directed_cases();
    set_limits(16'd3, 16'd5);
    // new user with id zero at time zero, then minute limit
    send_request(USER_LOW, 32'd0);
    send_request(USER_LOW, 32'd10);
    send_request(USER_LOW, 32'd20);
    // gap of 59 keeps the minute count
    send_request(USER_LOW, 32'd79);
    // gap of exactly 60 clears minute, hour limit reached
    send_request(USER_LOW, 32'd139);
    // gap of 3599 keeps the hour count
    send_request(USER_LOW, 32'd3738);
    // gap of exactly 3600 clears both
    send_request(USER_LOW, 32'd7338);
    // time going backwards clears nothing
    send_request(USER_LOW, 32'd7000);
    send_request(USER_LOW, 32'd6000);
    // all-ones user near the end of time: resume time needs the 33rd bit
    send_request(USER_HIGH, 32'hffff_fff0);
    send_request(USER_HIGH, 32'hffff_ffff);
    send_request(USER_HIGH, 32'hffff_ffff);
    // zero minute limit: any known user is limited, a new one is not
    write_reg(REG_LIMIT_MINUTE, 16'd0);
    send_request(USER_HIGH, 32'hffff_ffff);
    send_request(USER_MID, 32'd5);
    send_request(USER_MID, 32'd5);
    // limit of one after a long gap still points at last request plus a minute
    write_reg(REG_LIMIT_MINUTE, 16'd1);
    send_request(USER_MID, 32'd100000);
    // zero hour limit under a high minute limit
    set_limits(COUNT_MAX, 16'd0);
    send_request(USER_MID, 32'd100001);
  endtask

  // one random request: mostly users already seen, often the recent ones
  task automatic random_request();
    logic [31:0] user;
    int unsigned pick;
    int unsigned recent;
    pick = $urandom_range(0, 99);
    recent = (user_pool.size() < 8) ? user_pool.size() : 8;
    if (pick < 45) begin
      user = user_pool[user_pool.size() - 1 - $urandom_range(0, recent - 1)];
    end else if (pick < 80) begin
      user = user_pool[$urandom_range(0, user_pool.size() - 1)];
    end else begin
      user = $urandom;
      user_pool.push_back(user);
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) wall_clock += $urandom_range(0, 15);
    else if (pick < 80) wall_clock += $urandom_range(55, 65);
    else if (pick < 90) wall_clock += $urandom_range(3595, 3605);
    else if (pick < 97) wall_clock -= $urandom_range(1, 120);
    else wall_clock = $urandom;
    send_request(user, wall_clock);
  endtask

  // random traffic over several limit settings; the table fills up along the way
  task automatic test_random_traffic();
    user_pool = '{USER_DEFAULTS, USER_BUSY, USER_LOW, USER_HIGH, USER_MID};
    wall_clock = 32'd200000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ENABLE, 16'd1);
          set_limits(16'($urandom_range(2, 6)), 16'($urandom_range(5, 40)));
        end
        1: begin
          // no idling on either side
          set_limits(16'd1, COUNT_MAX);
          send_gaps = 1'b0;
          rsp_idling <= 1'b0;
        end
        2: begin
          set_limits(16'($urandom_range(4, 12)), 16'($urandom_range(10, 60)));
          send_gaps = 1'b1;
          rsp_idling <= 1'b1;
          // receiver goes quiet while requests keep coming
          hold_go <= 1'b1;
        end
        3: write_reg(REG_ENABLE, 16'd0);
        4: begin
          write_reg(REG_ENABLE, 16'd1);
          set_limits(16'd0, 16'($urandom));
        end
        default: set_limits(16'($urandom), 16'($urandom_range(1, 20)));
      endcase
      repeat (PHASE_WORDS) random_request();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled();
    test_reset_limits();
    test_busy_user();
    test_directed_cases();
    test_random_traffic();

    req_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // anything arriving now is an extra word
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d register writes, %0d limited, %0d untracked (table full)",
             words_sent, reg_writes, limited_seen, full_seen);
    $display("run: %0d cycles, %0d with the request side held off, %0d mismatches",
             cycle_count, backpressure_cycles, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
